>>> src/rap_pkg.sv
// Shared types and constants for the array message parser.
package rap_pkg;

  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam int QUEUE_DEPTH = 4;
  localparam int SLOTS       = 3;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       isint;
    logic       status;
  } slot_t;

  typedef struct packed {
    slot_t [SLOTS-1:0] slots;
    logic [1:0]        cnt;
  } bundle_t;

endpackage

>>> src/resp_array_parser.sv
// Top level of the streaming array message parser.
//
// Input channel: push/full with byte_in and message_end; a byte transfers on
// a rising edge with push high and full low. message_end marks the final
// byte of a message.
// Result channel: empty/pop with kind, data_byte, is_integer, status, last;
// the oldest result is shown while empty is low and transfers on an edge
// with pop high and empty low. last marks the final result of one byte.
// Each byte is parsed in the cycle it transfers; its results (zero to three)
// enter the queue as one bundle, shown after all earlier results.
// Throughput: one byte per cycle while each byte yields at most one result
// and pop stays high; a byte with n results holds the result port until
// all n are popped; a four-entry bundle queue between the stages absorbs it.
// When pop stays low the queue fills and full rises; no byte or result is
// lost. Reset clears parser state and the queue; the next byte must be '*'.
module resp_array_parser #(
  parameter int LEN_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] byte_in,
  input  logic       message_end,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] kind,
  output logic [7:0] data_byte,
  output logic       is_integer,
  output logic       status,
  output logic       last
);
  import rap_pkg::*;

  logic    wr, rd;
  bundle_t wr_bundle, rd_bundle;

  rap_front #(
    .LEN_BITS (LEN_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .take        (push && !full),
    .byte_in     (byte_in),
    .message_end (message_end),
    .wr          (wr),
    .wr_bundle   (wr_bundle)
  );

  rap_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr        (wr),
    .wr_bundle (wr_bundle),
    .rd        (rd),
    .rd_bundle (rd_bundle),
    .full      (full),
    .empty     (empty)
  );

  rap_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (rd_bundle),
    .head_empty (empty),
    .head_rd    (rd),
    .pop        (pop),
    .kind       (kind),
    .data_byte  (data_byte),
    .is_integer (is_integer),
    .status     (status),
    .last       (last)
  );

endmodule

>>> src/rap_front.sv
// Byte parser: tracks message state and packs the results of each byte.
module rap_front #(
  parameter int LEN_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  logic [7:0]       byte_in,
  input  logic             message_end,
  output logic             wr,
  output rap_pkg::bundle_t wr_bundle
);
  import rap_pkg::*;

  localparam int W = LEN_BITS;

  typedef enum logic [4:0] {
    PH_MARK  = 5'b00001,
    PH_COUNT = 5'b00010,
    PH_ELEM  = 5'b00100,
    PH_BULK  = 5'b01000,
    PH_ERR   = 5'b10000
  } phase_t;

  typedef struct packed {
    phase_t       phase;
    logic [W-1:0] decl;
    logic [W-1:0] elem;
    logic [W-1:0] blen;
    logic [W-1:0] tlen;
    logic [7:0]   lead;
    logic         bad;
  } pst_t;

  pst_t st, st_next;
  logic cr_pending, cr_pending_next;

  function automatic pst_t digit(input pst_t s_in, input logic [7:0] b);
    pst_t         s;
    logic [W+3:0] v;
    s = s_in;
    v = ({4'b0, s.blen} << 3) + ({4'b0, s.blen} << 1) + (W+4)'(b - CH_ZERO);
    if (b < CH_ZERO || b > CH_NINE) begin
      s.bad = 1'b1;
    end else if (!s.bad) begin
      if (v > {4'b0, {W{1'b1}}}) begin
        s.bad = 1'b1;
      end else begin
        s.blen = v[W-1:0];
      end
    end
    return s;
  endfunction

  function automatic pst_t feed(input pst_t s_in, input logic [7:0] b,
                                output slot_t o, output logic ov);
    pst_t s;
    s = s_in;
    o = '0;
    ov = 1'b0;
    case (s.phase)
      PH_COUNT: s = digit(s, b);
      PH_ELEM: begin
        if (s.tlen == '0) begin
          s.lead = b;
          if (b == CH_COLON) begin
            ov = 1'b1;
            o.kind = KIND_DATA;
            o.data = b;
            o.isint = 1'b1;
          end
        end else if (s.lead == CH_COLON) begin
          ov = 1'b1;
          o.kind = KIND_DATA;
          o.data = b;
          o.isint = 1'b1;
        end else if (s.lead == CH_DOLLAR) begin
          s = digit(s, b);
        end
      end
      PH_BULK: begin
        ov = 1'b1;
        o.kind = KIND_DATA;
        o.data = b;
      end
      default: ;
    endcase
    if (s.phase == PH_COUNT || s.phase == PH_ELEM || s.phase == PH_BULK) begin
      if (s.tlen != {W{1'b1}}) begin
        s.tlen = s.tlen + W'(1);
      end else if (s.phase == PH_BULK) begin
        s.bad = 1'b1;
      end
    end
    return s;
  endfunction

  function automatic pst_t accept_elem(input pst_t s_in, input logic isint,
                                       output slot_t o, output logic ov);
    pst_t s;
    s = s_in;
    o = '0;
    ov = 1'b0;
    if (s.elem >= s.decl) begin
      s.phase = PH_ERR;
    end else begin
      s.elem = s.elem + W'(1);
      ov = 1'b1;
      o.kind = KIND_ACCEPT;
      o.isint = isint;
    end
    return s;
  endfunction

  function automatic pst_t end_token(input pst_t s_in, output slot_t o,
                                     output logic ov);
    pst_t s;
    s = s_in;
    o = '0;
    ov = 1'b0;
    case (s.phase)
      PH_COUNT: begin
        if (s.bad || s.tlen == '0) begin
          s.phase = PH_ERR;
        end else begin
          s.decl = s.blen;
          s.blen = '0;
          s.phase = PH_ELEM;
        end
      end
      PH_ELEM: begin
        if (s.tlen == '0) begin
          s.phase = PH_ERR;
        end else if (s.lead == CH_COLON) begin
          s = accept_elem(s, 1'b1, o, ov);
        end else if (s.lead == CH_DOLLAR) begin
          if (s.bad || s.tlen < W'(2)) begin
            s.phase = PH_ERR;
          end else begin
            s.phase = PH_BULK;
          end
        end else begin
          s.phase = PH_ERR;
        end
      end
      PH_BULK: begin
        if (s.blen == '0 || s.bad || s.tlen != s.blen) begin
          s.phase = PH_ERR;
        end else begin
          s.blen = '0;
          s.phase = PH_ELEM;
          s = accept_elem(s, 1'b0, o, ov);
        end
      end
      default: ;
    endcase
    s.tlen = '0;
    s.lead = '0;
    s.bad = 1'b0;
    return s;
  endfunction

  pst_t  st_reset;
  slot_t r0, r1, r2;
  logic  v0, v1, v2;

  assign st_reset = '{phase: PH_MARK, decl: '0, elem: '0, blen: '0, tlen: '0,
                      lead: '0, bad: 1'b0};

  always_comb begin
    st_next = st;
    cr_pending_next = cr_pending;
    r0 = '0;
    r1 = '0;
    r2 = '0;
    v0 = 1'b0;
    v1 = 1'b0;
    v2 = 1'b0;
    if (st.phase == PH_MARK) begin
      st_next.phase = (byte_in == CH_STAR) ? PH_COUNT : PH_ERR;
    end else if (cr_pending && byte_in == CH_LF) begin
      cr_pending_next = 1'b0;
      st_next = end_token(st, r1, v1);
    end else begin
      if (cr_pending) begin
        cr_pending_next = 1'b0;
        st_next = feed(st_next, CH_CR, r0, v0);
      end
      if (byte_in == CH_CR && !message_end) begin
        cr_pending_next = 1'b1;
      end else begin
        st_next = feed(st_next, byte_in, r1, v1);
      end
    end
    if (message_end) begin
      v2 = 1'b1;
      r2.kind = KIND_STATUS;
      r2.status = !(st_next.phase != PH_ERR && st_next.decl != '0 &&
                    st_next.elem == st_next.decl);
      st_next = st_reset;
      cr_pending_next = 1'b0;
    end
  end

  always_comb begin
    wr_bundle.slots[0] = v0 ? r0 : (v1 ? r1 : r2);
    wr_bundle.slots[1] = (v0 && v1) ? r1 : r2;
    wr_bundle.slots[2] = r2;
    wr_bundle.cnt = 2'({1'b0, v0} + {1'b0, v1} + {1'b0, v2});
    wr = take && (v0 || v1 || v2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= st_reset;
      cr_pending <= 1'b0;
    end else if (take) begin
      st <= st_next;
      cr_pending <= cr_pending_next;
    end
  end

  a_cr_not_mark: assert property (@(posedge clk) disable iff (rst)
    cr_pending |-> st.phase != PH_MARK)
    else $error("held CR while waiting for array marker");

  a_elem_bound: assert property (@(posedge clk) disable iff (rst)
    st.elem <= st.decl)
    else $error("element count beyond declared count");

endmodule

>>> src/rap_queue.sv
// Short queue of result bundles between parser and result serializer.
module rap_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  rap_pkg::bundle_t wr_bundle,
  input  logic             rd,
  output rap_pkg::bundle_t rd_bundle,
  output logic             full,
  output logic             empty
);
  import rap_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);

  bundle_t      mem [QUEUE_DEPTH];
  logic [AW-1:0] wptr, rptr;
  logic [AW:0]   count;
  logic          do_wr, do_rd;

  assign full = count == (AW+1)'(QUEUE_DEPTH);
  assign empty = count == '0;
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rd_bundle = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wr_bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == AW'(QUEUE_DEPTH - 1)) ? '0 : wptr + AW'(1);
      end
      if (do_rd) begin
        rptr <= (rptr == AW'(QUEUE_DEPTH - 1)) ? '0 : rptr + AW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + (AW+1)'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - (AW+1)'(1);
      end
    end
  end

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    !(wr && full))
    else $error("bundle written into full queue");

  a_count_ptr: assert property (@(posedge clk) disable iff (rst)
    (count == '0 || count == (AW+1)'(QUEUE_DEPTH)) |-> wptr == rptr)
    else $error("queue pointers disagree with count");

endmodule

>>> src/rap_back.sv
// Result serializer: hands out the slots of each bundle one transfer at a time.
module rap_back (
  input  logic             clk,
  input  logic             rst,
  input  rap_pkg::bundle_t head,
  input  logic             head_empty,
  output logic             head_rd,
  input  logic             pop,
  output logic [1:0]       kind,
  output logic [7:0]       data_byte,
  output logic             is_integer,
  output logic             status,
  output logic             last
);
  import rap_pkg::*;

  logic [1:0] idx;
  slot_t      cur;
  logic       take;

  assign cur = head.slots[idx];
  assign kind = cur.kind;
  assign data_byte = cur.data;
  assign is_integer = cur.isint;
  assign status = cur.status;
  assign last = idx == head.cnt - 2'd1;
  assign take = pop && !head_empty;
  assign head_rd = take && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (take) begin
      idx <= last ? '0 : idx + 2'd1;
    end
  end

  a_idx_in_bundle: assert property (@(posedge clk) disable iff (rst)
    !head_empty |-> (head.cnt != 2'd0 && idx < head.cnt))
    else $error("slot index outside current bundle");

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// Testbench for resp_array_parser: random and directed array messages, every result checked.

import rap_pkg::*;

localparam int unsigned LEN_BITS = 16;
localparam int unsigned LEN_MAX = (1 << LEN_BITS) - 1;

localparam logic ST_OK  = 1'b0;
localparam logic ST_ERR = 1'b1;

typedef enum logic [2:0] {
  P_MARKER,
  P_COUNT,
  P_ELEMENT,
  P_BULK,
  P_ERROR
} parse_phase_t;

typedef struct packed {
  kind_t      kind;
  logic [7:0] data;
  logic       isint;
  logic       status;
  logic       last;
} parse_result_t;

typedef struct packed {
  logic [7:0] value;
  logic       fin;
} stim_byte_t;

class parse_scoreboard;
  parse_phase_t  phase;
  bit            cr_held;
  int unsigned   declared_cnt;
  int unsigned   element_cnt;
  int unsigned   number_acc;
  int unsigned   token_len;
  logic [7:0]    token_first;
  bit            number_bad;
  parse_result_t parse_results_q[$];
  parse_result_t byte_results[$];
  int            errors;

  function new();
    errors = 0;
    clear_parse();
  endfunction

  function void clear_parse();
    phase = P_MARKER;
    cr_held = 0;
    declared_cnt = 0;
    element_cnt = 0;
    number_acc = 0;
    token_len = 0;
    token_first = '0;
    number_bad = 0;
  endfunction

  function void emit(kind_t k, logic [7:0] d, logic isint, logic st);
    byte_results.push_back('{k, d, isint, st, 1'b0});
  endfunction

  function void count_token_byte();
    if (token_len < LEN_MAX) token_len++;
    else if (phase == P_BULK) number_bad = 1;
  endfunction

  function void take_digit(logic [7:0] b);
    int unsigned v;
    if (b < CH_ZERO || b > CH_NINE) begin
      number_bad = 1;
      return;
    end
    if (number_bad) return;
    v = number_acc * 10 + int'(b - CH_ZERO);
    if (v > LEN_MAX) number_bad = 1;
    else number_acc = v;
  endfunction

  function void feed(logic [7:0] b);
    case (phase)
      P_COUNT: begin
        take_digit(b);
        count_token_byte();
      end
      P_ELEMENT: begin
        if (token_len == 0) begin
          token_first = b;
          if (b == CH_COLON) emit(KIND_DATA, b, 1'b1, ST_OK);
        end else if (token_first == CH_COLON) begin
          emit(KIND_DATA, b, 1'b1, ST_OK);
        end else if (token_first == CH_DOLLAR) begin
          take_digit(b);
        end
        count_token_byte();
      end
      P_BULK: begin
        emit(KIND_DATA, b, 1'b0, ST_OK);
        count_token_byte();
      end
      default: ;
    endcase
  endfunction

  function void accept_element(logic isint);
    if (element_cnt >= declared_cnt) begin
      phase = P_ERROR;
      return;
    end
    element_cnt++;
    emit(KIND_ACCEPT, 8'h00, isint, ST_OK);
  endfunction

  function void end_token();
    case (phase)
      P_COUNT: begin
        if (number_bad || token_len == 0) begin
          phase = P_ERROR;
        end else begin
          declared_cnt = number_acc;
          number_acc = 0;
          phase = P_ELEMENT;
        end
      end
      P_ELEMENT: begin
        if (token_len == 0) phase = P_ERROR;
        else if (token_first == CH_COLON) accept_element(1'b1);
        else if (token_first == CH_DOLLAR) begin
          if (number_bad || token_len < 2) phase = P_ERROR;
          else phase = P_BULK;
        end else phase = P_ERROR;
      end
      P_BULK: begin
        if (number_acc == 0 || number_bad || token_len != number_acc) begin
          phase = P_ERROR;
        end else begin
          number_acc = 0;
          phase = P_ELEMENT;
          accept_element(1'b0);
        end
      end
      default: ;
    endcase
    token_len = 0;
    token_first = '0;
    number_bad = 0;
  endfunction

  function void parse_byte(logic [7:0] b, logic fin);
    byte_results.delete();
    if (phase == P_MARKER) begin
      phase = (b == CH_STAR) ? P_COUNT : P_ERROR;
    end else if (cr_held && b == CH_LF) begin
      cr_held = 0;
      end_token();
    end else begin
      if (cr_held) begin
        cr_held = 0;
        feed(CH_CR);
      end
      if (b == CH_CR && !fin) cr_held = 1;
      else feed(b);
    end
    if (fin) begin
      emit(KIND_STATUS, 8'h00, 1'b0,
           (phase != P_ERROR && declared_cnt > 0 && element_cnt == declared_cnt)
             ? ST_OK : ST_ERR);
      clear_parse();
    end
    if (byte_results.size() > 0) byte_results[byte_results.size() - 1].last = 1'b1;
    foreach (byte_results[i]) parse_results_q.push_back(byte_results[i]);
  endfunction

  function int pending();
    return parse_results_q.size();
  endfunction

  task report(string what);
    errors++;
    if (errors <= 40) $display("MISMATCH at %0t: %s", $time, what);
  endtask

  task check_result(parse_result_t got);
    parse_result_t want;
    if (parse_results_q.size() == 0) begin
      report($sformatf("unexpected result kind=%0d data=%02h int=%0b st=%0b last=%0b",
                       got.kind, got.data, got.isint, got.status, got.last));
      return;
    end
    want = parse_results_q.pop_front();
    if (got.kind !== want.kind || got.data !== want.data || got.isint !== want.isint ||
        got.status !== want.status || got.last !== want.last)
      report($sformatf("got %0d %02h %0b %0b %0b, want %0d %02h %0b %0b %0b",
                       got.kind, got.data, got.isint, got.status, got.last,
                       want.kind, want.data, want.isint, want.status, want.last));
  endtask
endclass

module testbench;
  localparam int CYCLE_LIMIT = 400000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic [7:0] byte_in = 8'h00;
  logic       message_end = 1'b0;
  logic       pop = 1'b0;
  logic       full;
  logic       empty;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic       is_integer;
  logic       status;
  logic       last;

  parse_scoreboard sb = new();
  stim_byte_t      stim_q[$];
  int              rx_mode = 0;
  int              rx_mode_left = 0;
  int              rx_stall = 0;

  resp_array_parser #(.LEN_BITS(LEN_BITS)) DUT (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .byte_in(byte_in),
    .message_end(message_end),
    .empty(empty),
    .pop(pop),
    .kind(kind),
    .data_byte(data_byte),
    .is_integer(is_integer),
    .status(status),
    .last(last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function void put_b(logic [7:0] b);
    stim_q.push_back('{b, 1'b0});
  endfunction

  function automatic void put_s(string s);
    for (int i = 0; i < s.len(); i++) put_b(s[i]);
  endfunction

  function void put_crlf();
    put_b(CH_CR);
    put_b(CH_LF);
  endfunction

  function void put_num(int unsigned n);
    put_s($sformatf("%0d", n));
  endfunction

  function void end_msg();
    stim_q[stim_q.size() - 1].fin = 1'b1;
  endfunction

  function automatic logic [7:0] rand_data();
    logic [7:0] b;
    do b = 8'($urandom); while (b == CH_CR);
    return b;
  endfunction

  function automatic void gen_message();
    int start;
    int n;
    int decl;
    int len;
    int k;
    start = stim_q.size();
    if ($urandom_range(0, 99) < 12) begin
      n = $urandom_range(1, 10);
      if ($urandom_range(0, 1) != 0) put_b(CH_STAR);
      repeat (n) put_b(8'($urandom));
    end else begin
      n = $urandom_range(1, 4);
      case ($urandom_range(0, 19))
        0: decl = n + 1;
        1: decl = n - 1;
        2: decl = 0;
        3: decl = LEN_MAX;
        4: decl = LEN_MAX + 1;
        default: decl = n;
      endcase
      put_b(CH_STAR);
      put_num(decl);
      put_crlf();
      repeat (n) begin
        if ($urandom_range(0, 1) != 0) begin
          put_b(CH_COLON);
          k = $urandom_range(0, 5);
          repeat (k)
            put_b(($urandom_range(0, 3) != 0) ?
                  8'($urandom_range(CH_ZERO, CH_NINE)) : rand_data());
        end else begin
          len = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 6);
          put_b(CH_DOLLAR);
          case ($urandom_range(0, 24))
            0: put_num(LEN_MAX);
            1: put_num(LEN_MAX + 1);
            2: put_s("1x");
            default: put_num(len);
          endcase
          put_crlf();
          k = len;
          if ($urandom_range(0, 9) == 0)
            k = (len > 0 && $urandom_range(0, 1) != 0) ? len - 1 : len + 1;
          repeat (k) put_b(($urandom_range(0, 11) == 0) ? CH_CR : rand_data());
          put_crlf();
        end
      end
      if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) put_b(rand_data());
      if ($urandom_range(0, 6) == 0)
        stim_q[start + $urandom_range(0, stim_q.size() - start - 1)].value = 8'($urandom);
      if ($urandom_range(0, 9) == 0) begin
        k = $urandom_range(1, stim_q.size() - start - 1);
        repeat (k) void'(stim_q.pop_back());
      end
    end
    end_msg();
  endfunction

  task send_byte(stim_byte_t s);
    @(negedge clk);
    push <= 1'b1;
    byte_in <= s.value;
    message_end <= s.fin;
    do @(posedge clk); while (full);
  endtask

  task hold_off(int n);
    @(negedge clk);
    push <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && push && !full) sb.parse_byte(byte_in, message_end);
    if (!rst && pop && !empty)
      sb.check_result('{kind_t'(kind), data_byte, is_integer, status, last});
  end

  always @(negedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_mode_left = $urandom_range(50, 300);
    end
    rx_mode_left--;
    if (rx_stall > 0) begin
      rx_stall--;
      pop <= 1'b0;
    end else if (rx_mode == 1 && $urandom_range(0, 3) == 0) begin
      rx_stall = $urandom_range(0, 3);
      pop <= 1'b0;
    end else if (rx_mode == 2 && $urandom_range(0, 9) == 0) begin
      rx_stall = $urandom_range(5, 20);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int idx;
    int burst;
    int directed_end;
    int drain_at;

    // lone CR and extreme bytes inside an integer, then one element too many
    put_b(CH_STAR);
    put_s("1");
    put_crlf();
    put_b(CH_COLON);
    put_b(8'hFF);
    put_b(CH_CR);
    put_b(8'h00);
    put_crlf();
    put_b(CH_COLON);
    put_crlf();
    end_msg();
    // wrong first byte
    put_b(8'h00);
    end_msg();
    // zero length bulk header
    put_b(CH_STAR);
    put_s("1");
    put_crlf();
    put_b(CH_DOLLAR);
    put_s("0");
    put_crlf();
    put_crlf();
    end_msg();
    // CR as the final byte
    put_b(CH_STAR);
    put_b(CH_CR);
    end_msg();
    directed_end = stim_q.size();
    while (stim_q.size() < directed_end + 220) gen_message();
    drain_at = directed_end + (stim_q.size() - directed_end) / 2;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    idx = 0;
    while (idx < stim_q.size()) begin
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      while (burst > 0 && idx < stim_q.size()) begin
        send_byte(stim_q[idx]);
        idx++;
        burst--;
        if (idx == directed_end || idx == drain_at) begin
          hold_off(1);
          wait_drained();
        end
      end
      if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 6));
    end
    hold_off(1);
    wait_drained();
    repeat (8) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
